>>> hw/rtl/g2h_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package g2h_pkg;
	localparam int YearMin  = 1900;
	localparam int YearMax  = 2399;
	localparam int HebOffset = 3760;
	localparam int Epoch    = -1373427;

	// Reciprocals for division by a constant: ceil(2^k / d).
	localparam int Recip100  = 5243;      // d = 100, k = 19
	localparam int WdRecip   = 1198373;   // d = 7, k = 23
	localparam int MonRecip  = 1766023;   // d = 19, k = 25
	localparam int PartRecip = 10604858;  // d = 405, k = 32
	localparam int D7Recip   = 4793491;   // d = 7, k = 25
	localparam int Recip19L  = 55189;     // d = 19, k = 20
	localparam int Recip10   = 205;       // d = 10, k = 11

	typedef struct packed {
		logic [11:0] cal_year;
		logic [3:0]  cal_month;
		logic [4:0]  cal_day;
	} g2h_req_t;

	typedef struct packed {
		logic [12:0] hebrew_year;
		logic [3:0]  hebrew_month;
		logic [4:0]  hebrew_day;
		logic [2:0]  weekday;
		logic        leap_flag;
	} g2h_rsp_t;

	typedef enum logic [3:0] {
		OP_NONE  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_FIXQ  = 4'd2,
		OP_FIXD  = 4'd3,
		OP_WDQ   = 4'd4,
		OP_WDR   = 4'd5,
		OP_EMON  = 4'd6,
		OP_EPRT  = 4'd7,
		OP_EDAY  = 4'd8,
		OP_EQ7   = 4'd9,
		OP_EWR   = 4'd10,
		OP_NYEAR = 4'd11,
		OP_YSTEP = 4'd12,
		OP_MSTEP = 4'd13
	} g2h_op_t;

	typedef struct packed {
		g2h_op_t    op;
		logic [1:0] idx;
	} g2h_cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} g2h_sts_t;

	// Month start within year, days before Gregorian month (non-leap, Jan = 1).
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] r;
		begin
			case (m)
				4'd1:    r = 9'd0;
				4'd2:    r = 9'd31;
				4'd3:    r = 9'd59;
				4'd4:    r = 9'd90;
				4'd5:    r = 9'd120;
				4'd6:    r = 9'd151;
				4'd7:    r = 9'd181;
				4'd8:    r = 9'd212;
				4'd9:    r = 9'd243;
				4'd10:   r = 9'd273;
				4'd11:   r = 9'd304;
				default: r = 9'd334;
			endcase
			return r;
		end
	endfunction

	function automatic logic heb_leap(input logic [12:0] y);
		logic [16:0] t;
		logic [11:0] q;
		logic [4:0]  r;
		begin
			t = 17'(y) * 17'd7 + 17'd1;
			q = 12'((34'(t) * 34'(Recip19L)) >> 20);
			r = 5'(t - 17'(q) * 17'd19);
			return r < 5'd7;
		end
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/g2h_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface g2h_in_if;
	logic valid;
	logic ready;
	g2h_pkg::g2h_req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface g2h_out_if;
	logic valid;
	logic ready;
	g2h_pkg::g2h_rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/g2h_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module g2h_datapath (
	input  wire logic              clk,
	input  wire g2h_pkg::g2h_cmd_t cmd,
	input  wire g2h_pkg::g2h_req_t req,
	output g2h_pkg::g2h_sts_t      sts,
	output g2h_pkg::g2h_rsp_t      rsp
);
	import g2h_pkg::*;

	logic [11:0] gy_q;
	logic [3:0]  gm_q;
	logic [4:0]  gd_q;
	logic [4:0]  gq_q;
	logic [4:0]  pq_q;
	logic [19:0] fixed_q;
	logic [16:0] wq_q;
	logic [2:0]  wd_q;
	logic [12:0] hy_q;
	logic [16:0] months_q;
	logic [29:0] parts_q;
	logic [21:0] days_q;
	logic [18:0] q7_q;
	logic [19:0] el_q [0:3];
	logic [19:0] ny_q [0:1];
	logic        leap_q;
	logic [19:0] rem_q;
	logic [3:0]  m_q;
	logic [8:0]  ylen_q;

	logic [11:0] gy;
	logic [3:0]  gm;
	logic [11:0] p;
	logic [6:0]  gr;
	logic        gleap;
	logic [21:0] fx;
	logic [12:0] ey;
	logic [20:0] num;
	logic [21:0] days1;
	logic [2:0]  r7;
	logic        post;
	logic [19:0] nyv;
	logic [5:0]  yq;
	logic [3:0]  ymod;
	logic [4:0]  mlen;
	logic [3:0]  mm;

	always_comb begin
		gy = req.cal_year;
		if (gy < 12'(YearMin)) gy = 12'(YearMin);
		if (gy > 12'(YearMax)) gy = 12'(YearMax);
		gm = req.cal_month;
		if (gm == 4'd0) gm = 4'd1;
		if (gm > 4'd12) gm = 4'd12;
	end

	always_comb begin
		p = gy_q - 12'd1;
		gr = 7'(gy_q - 12'(gq_q) * 12'd100);
		gleap = (gy_q[1:0] == 2'd0) && ((gr != 7'd0) || (gq_q[1:0] == 2'd0));
		fx = 22'(p) * 22'd365 + 22'(p[11:2]) - 22'(pq_q) + 22'(pq_q[4:2])
			+ 22'(month_start(gm_q)) + 22'(gd_q)
			+ ((gm_q > 4'd2 && gleap) ? 22'd1 : 22'd0);
	end

	// Elapsed days of year hy_q - 1 + idx, one step per cycle.
	always_comb begin
		ey = hy_q + 13'(cmd.idx) - 13'd1;
		num = 21'(ey) * 21'd235 - 21'd234;
		days1 = days_q + 22'd1;
		r7 = 3'(days1 - 22'(q7_q) * 22'd7);
		post = (r7 == 3'd0) || (r7 == 3'd3) || (r7 == 3'd5);
	end

	// New year of hy_q + idx from el_q[idx..idx+2].
	always_comb begin
		nyv = el_q[cmd.idx+2'd1];
		if (el_q[cmd.idx+2'd2] - el_q[cmd.idx+2'd1] == 20'd356)
			nyv = nyv + 20'd2;
		else if (el_q[cmd.idx+2'd1] - el_q[cmd.idx] == 20'd382)
			nyv = nyv + 20'd1;
	end

	always_comb begin
		yq = 6'((18'(ylen_q) * 18'(Recip10)) >> 11);
		ymod = 4'(ylen_q - 9'(yq) * 9'd10);
		mm = m_q;
		case (m_q)
			4'd0:    mlen = 5'd30;
			4'd1:    mlen = (ymod == 4'd5) ? 5'd30 : 5'd29;
			4'd2:    mlen = (ymod == 4'd3) ? 5'd29 : 5'd30;
			4'd3:    mlen = 5'd29;
			4'd4:    mlen = 5'd30;
			default: begin
				if (leap_q && m_q == 4'd5) mlen = 5'd30;
				else if (leap_q && m_q == 4'd6) mlen = 5'd29;
				else begin
					mm = leap_q ? m_q - 4'd7 : m_q - 4'd6;
					mlen = mm[0] ? 5'd29 : 5'd30;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				gy_q <= gy;
				gm_q <= gm;
				gd_q <= req.cal_day;
				hy_q <= 13'(gy) + 13'(HebOffset);
				m_q <= 4'd0;
			end
			OP_FIXQ: begin
				gq_q <= 5'((25'(gy_q) * 25'(Recip100)) >> 19);
				pq_q <= 5'((25'(p) * 25'(Recip100)) >> 19);
			end
			OP_FIXD: fixed_q <= 20'(fx);
			OP_WDQ: wq_q <= 17'((41'(fixed_q) * 41'(WdRecip)) >> 23);
			OP_WDR: wd_q <= 3'(fixed_q - 20'(wq_q) * 20'd7);
			OP_EMON: months_q <= 17'((42'(num) * 42'(MonRecip)) >> 25);
			OP_EPRT: parts_q <= 30'd12084 + 30'(months_q) * 30'd13753;
			OP_EDAY: days_q <= 22'(months_q) * 22'd29
				+ 22'((48'(parts_q[29:6]) * 48'(PartRecip)) >> 32);
			OP_EQ7: q7_q <= 19'((46'(days1) * 46'(D7Recip)) >> 25);
			OP_EWR: el_q[cmd.idx] <= 20'(days_q + 22'(post) + 22'(Epoch));
			OP_NYEAR: begin
				ny_q[cmd.idx[0]] <= nyv;
				leap_q <= heb_leap(hy_q);
			end
			OP_YSTEP: begin
				if (fixed_q >= ny_q[1]) hy_q <= hy_q + 13'd1;
				else if (fixed_q < ny_q[0]) hy_q <= hy_q - 13'd1;
				rem_q <= fixed_q - ny_q[0];
				ylen_q <= 9'(ny_q[1] - ny_q[0]);
			end
			OP_MSTEP: begin
				if (m_q < 4'd12 && rem_q >= 20'(mlen)) begin
					rem_q <= rem_q - 20'(mlen);
					m_q <= m_q + 4'd1;
				end
			end
			default: ;
		endcase
	end

	assign sts.year_done = (fixed_q < ny_q[1]) && (fixed_q >= ny_q[0]);
	assign sts.month_done = !(m_q < 4'd12 && rem_q >= 20'(mlen));
	assign rsp.hebrew_year = hy_q;
	assign rsp.hebrew_month = m_q;
	assign rsp.hebrew_day = 5'(rem_q + 20'd1);
	assign rsp.weekday = wd_q + 3'd1;
	assign rsp.leap_flag = leap_q;
endmodule
`default_nettype wire

>>> hw/rtl/g2h_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module g2h_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire g2h_pkg::g2h_sts_t sts,
	output g2h_pkg::g2h_cmd_t      cmd
);
	import g2h_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_FIX   = 7'b0000010,
		ST_ELAPS = 7'b0000100,
		ST_NYEAR = 7'b0001000,
		ST_YSTEP = 7'b0010000,
		ST_MSTEP = 7'b0100000,
		ST_DONE  = 7'b1000000
	} state_t;

	state_t     state_q;
	logic [1:0] idx_q;
	logic [2:0] step_q;

	always_comb begin
		cmd.op = OP_NONE;
		cmd.idx = idx_q;
		unique case (state_q)
			ST_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
			ST_FIX: begin
				unique case (step_q)
					3'd0:    cmd.op = OP_FIXQ;
					3'd1:    cmd.op = OP_FIXD;
					3'd2:    cmd.op = OP_WDQ;
					default: cmd.op = OP_WDR;
				endcase
			end
			ST_ELAPS: begin
				unique case (step_q)
					3'd0:    cmd.op = OP_EMON;
					3'd1:    cmd.op = OP_EPRT;
					3'd2:    cmd.op = OP_EDAY;
					3'd3:    cmd.op = OP_EQ7;
					default: cmd.op = OP_EWR;
				endcase
			end
			ST_NYEAR: cmd.op = OP_NYEAR;
			ST_YSTEP: cmd.op = OP_YSTEP;
			ST_MSTEP: cmd.op = OP_MSTEP;
			ST_DONE:  cmd.op = OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;
	assign out_valid = state_q == ST_DONE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= 2'd0;
			step_q <= 3'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					state_q <= ST_FIX;
					idx_q <= 2'd0;
					step_q <= 3'd0;
				end
				ST_FIX: if (step_q == 3'd3) begin
					step_q <= 3'd0;
					state_q <= ST_ELAPS;
				end else begin
					step_q <= step_q + 3'd1;
				end
				ST_ELAPS: if (step_q == 3'd4) begin
					step_q <= 3'd0;
					if (idx_q == 2'd3) begin
						idx_q <= 2'd0;
						state_q <= ST_NYEAR;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end else begin
					step_q <= step_q + 3'd1;
				end
				ST_NYEAR: if (idx_q == 2'd1) begin
					idx_q <= 2'd0;
					state_q <= ST_YSTEP;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
				ST_YSTEP: state_q <= sts.year_done ? ST_MSTEP : ST_ELAPS;
				ST_MSTEP: if (sts.month_done) state_q <= ST_DONE;
				ST_DONE: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while busy");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_load_then_fix: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_FIX) else $error("bad start");
endmodule
`default_nettype wire

>>> hw/rtl/gregorian_to_hebrew_date_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Gregorian to Hebrew date converter. One request at a time: after a date is
// taken, FIXQ, FIXD, WDQ and WDR form the day count and weekday, then each
// Hebrew year try runs four elapsed-day evaluations (EMON, EPRT, EDAY, EQ7,
// EWR), the new years of two years and one compare; one or two tries are
// needed. The month walk steps one month at a time until the rest fits. The
// result holds until taken; the next request is accepted no earlier than the
// cycle after the result is taken.
module gregorian_to_hebrew_date_top (
	input wire logic clk,
	input wire logic arst_n,
	g2h_in_if.sink   in_ch,
	g2h_out_if.source out_ch
);
	import g2h_pkg::*;

	g2h_cmd_t cmd;
	g2h_sts_t sts;

	g2h_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	g2h_datapath u_dp (
		.clk(clk), .cmd(cmd), .req(in_ch.data), .sts(sts), .rsp(out_ch.data)
	);
endmodule
`default_nettype wire
